// File: rtl/rtba_pkg.sv
// Shared types, constants and codes for the two-tier block allocator.
package rtba_pkg;

    localparam int MaxBlocks  = 1024;
    localparam int IdW        = $clog2(MaxBlocks);
    localparam int CntW       = IdW + 1;
    localparam int RefW       = 16;
    localparam int StampW     = 32;
    localparam int CfgW       = 11;
    localparam int MinFastCap = 64;
    localparam int EntryW     = RefW + 1 + 1 + StampW;

    typedef enum logic [2:0] {
        MODE_ALLOC   = 3'd0,
        MODE_RELEASE = 3'd1,
        MODE_ADDREF  = 3'd2,
        MODE_TOUCH   = 3'd3,
        MODE_TOSLOW  = 3'd4,
        MODE_TOFAST  = 3'd5,
        MODE_MARK    = 3'd6,
        MODE_CLEAR   = 3'd7
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_BLOCK  = 3'd1,
        ST_BAD_ID    = 3'd2,
        ST_WRONG     = 3'd3,
        ST_FREE      = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        REG_TOTAL    = 2'd0,
        REG_SLOW     = 2'd1,
        REG_OVERFLOW = 2'd2
    } t_reg;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_POP  = 2'd2
    } t_state;

    typedef struct packed {
        logic [RefW-1:0]   ref_cnt;
        logic              tier;
        logic              dirty;
        logic [StampW-1:0] stamp;
    } t_entry;

endpackage

// File: rtl/refcounted_two_tier_block_allocator_unit.sv
// Top level: request sequencer over block-entry and free-stack memories.
// Result strobe: registered from the execute state, or from the pop state when allocation pops a stack.
// A new request is taken only while idle, not before the last one is done; busy covers execute and pop.
// A popped id is known only after the stack read, so its entry takes a second read.
// Reset: synchronous active-low; counters and stack tops clear, memories do not.
// Results cannot be stalled by the receiver.
module refcounted_two_tier_block_allocator_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [2:0]                            i_mode,
    input  logic [rtba_pkg::IdW-1:0]              i_block_id,
    input  logic                                  i_cfg_we,
    input  logic [1:0]                            i_cfg_index,
    input  logic [rtba_pkg::CfgW-1:0]             i_cfg_wdata,
    output logic                                  o_valid,
    output logic [2:0]                            o_status,
    output logic [rtba_pkg::IdW-1:0]              o_granted_id,
    output logic [rtba_pkg::RefW-1:0]             o_ref_now,
    output logic                                  o_tier_now,
    output logic                                  o_dirty_now,
    output logic [rtba_pkg::StampW-1:0]           o_stamp_now,
    output logic [rtba_pkg::CntW-1:0]             o_created_count,
    output logic [rtba_pkg::CntW-1:0]             o_fast_free_count,
    output logic [rtba_pkg::CntW-1:0]             o_slow_free_count,
    output logic [rtba_pkg::CntW-1:0]             o_in_use_count,
    output logic [31:0]                           o_to_slow_moves,
    output logic [31:0]                           o_to_fast_moves
);

    localparam int IdW  = rtba_pkg::IdW;
    localparam int CntW = rtba_pkg::CntW;
    localparam int RefW = rtba_pkg::RefW;
    localparam logic [CntW-1:0] MaxCnt = CntW'(rtba_pkg::MaxBlocks);

    rtba_pkg::t_state r_state, n_state;

    logic [rtba_pkg::CfgW-1:0] r_total, r_slow;
    logic                      r_ovf;

    logic [CntW-1:0] r_ftop, r_stop, r_next, r_floc, r_used;
    logic [31:0]     r_stampc, r_mv_slow, r_mv_fast;
    logic [2:0]      r_mode;
    logic [IdW-1:0]  r_id;
    logic [IdW-1:0]  r_pid;

    // memory ports
    logic               ent_we;
    logic [IdW-1:0]     ent_addr;
    rtba_pkg::t_entry   ent_wdata, ent_rdata;
    logic               fs_we, ss_we;
    logic [IdW-1:0]     fs_addr, ss_addr, fs_wdata, ss_wdata, fs_rdata, ss_rdata;

    rtba_ram #(.Width(rtba_pkg::EntryW), .Depth(rtba_pkg::MaxBlocks)) u_ent (
        .i_clk(i_clk), .i_we(ent_we), .i_addr(ent_addr),
        .i_wdata(ent_wdata), .o_rdata(ent_rdata)
    );
    rtba_ram #(.Width(IdW), .Depth(rtba_pkg::MaxBlocks)) u_fstk (
        .i_clk(i_clk), .i_we(fs_we), .i_addr(fs_addr),
        .i_wdata(fs_wdata), .o_rdata(fs_rdata)
    );
    rtba_ram #(.Width(IdW), .Depth(rtba_pkg::MaxBlocks)) u_sstk (
        .i_clk(i_clk), .i_we(ss_we), .i_addr(ss_addr),
        .i_wdata(ss_wdata), .o_rdata(ss_rdata)
    );

    logic take;
    logic done;
    assign take = start && !busy;
    assign busy = (r_state != rtba_pkg::S_IDLE);
    assign done = busy && (n_state == rtba_pkg::S_IDLE);

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= rtba_pkg::CfgW'(rtba_pkg::MaxBlocks);
            r_slow  <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rtba_pkg::REG_TOTAL:    r_total <= i_cfg_wdata;
                rtba_pkg::REG_SLOW:     r_slow  <= i_cfg_wdata;
                rtba_pkg::REG_OVERFLOW: r_ovf   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // read phase: addresses from request (stack tops minus one)
    logic [IdW-1:0] ftop_m1, stop_m1;
    assign ftop_m1 = IdW'(r_ftop - 1'b1);
    assign stop_m1 = IdW'(r_stop - 1'b1);

    // allocation decision (valid in EXEC; uses registered counts)
    logic signed [CntW+1:0] cap;
    logic                   can_new, fast_new, slow_new, ovf_ok;
    logic [CntW:0]          slow_lhs, slow_rhs;
    always_comb begin
        cap = $signed({2'b00, r_total});
        if (r_ovf) begin
            cap = $signed({2'b00, r_total}) - $signed({2'b00, r_slow});
            if (cap < (CntW+2)'(rtba_pkg::MinFastCap)) begin
                cap = (CntW+2)'(rtba_pkg::MinFastCap);
            end
        end
        can_new  = (r_next < MaxCnt);
        fast_new = ($signed({2'b00, r_floc}) < cap) && can_new;
        slow_lhs = {1'b0, r_stop} + {1'b0, r_used};
        slow_rhs = {1'b0, r_total} + {1'b0, r_slow};
        ovf_ok   = r_ovf;
        slow_new = (slow_lhs < slow_rhs) && can_new;
    end

    // execute
    rtba_pkg::t_entry e, ne;
    logic [2:0]       st;
    logic             show, popping, creating;
    logic [IdW-1:0]   gid;
    logic [CntW-1:0]  n_ftop, n_stop, n_next, n_floc, n_used;
    logic [31:0]      n_stampc, n_mv_slow, n_mv_fast;
    logic [31:0]      stamp1;

    always_comb begin
        n_state   = r_state;
        e         = ent_rdata;
        ne        = ent_rdata;
        st        = rtba_pkg::ST_OK;
        show      = 1'b0;
        popping   = 1'b0;
        creating  = 1'b0;
        gid       = r_id;
        n_ftop    = r_ftop;
        n_stop    = r_stop;
        n_next    = r_next;
        n_floc    = r_floc;
        n_used    = r_used;
        n_stampc  = r_stampc;
        n_mv_slow = r_mv_slow;
        n_mv_fast = r_mv_fast;
        stamp1    = r_stampc + 32'd1;
        ent_we    = 1'b0;
        fs_we     = 1'b0;
        ss_we     = 1'b0;
        fs_wdata  = r_id;
        ss_wdata  = r_id;
        ent_addr  = i_block_id;
        fs_addr   = ftop_m1;
        ss_addr   = stop_m1;

        unique case (r_state)
            rtba_pkg::S_IDLE: begin
                if (take) begin
                    n_state = rtba_pkg::S_EXEC;
                end
            end
            rtba_pkg::S_EXEC: begin
                n_state  = rtba_pkg::S_IDLE;
                ent_addr = r_id;
                if (r_mode == rtba_pkg::MODE_ALLOC) begin
                    if (r_ftop != '0) begin
                        popping = 1'b1;
                        gid     = fs_rdata;
                        n_ftop  = r_ftop - 1'b1;
                    end else if (fast_new) begin
                        creating = 1'b1;
                        gid = IdW'(r_next); ne.tier = 1'b0;
                        n_floc = r_floc + 1'b1;
                    end else if (ovf_ok && r_stop != '0) begin
                        popping = 1'b1;
                        gid     = ss_rdata;
                        n_stop  = r_stop - 1'b1;
                    end else if (ovf_ok && slow_new) begin
                        creating = 1'b1;
                        gid = IdW'(r_next); ne.tier = 1'b1;
                    end else begin
                        st  = rtba_pkg::ST_NO_BLOCK;
                        gid = '0;
                    end
                    if (popping) begin
                        // fetch the popped block's entry, grant in the pop cycle
                        n_state  = rtba_pkg::S_POP;
                        ent_addr = gid;
                    end else if (creating) begin
                        show       = 1'b1;
                        ent_we     = 1'b1;
                        ent_addr   = gid;
                        n_next     = r_next + 1'b1;
                        n_used     = r_used + 1'b1;
                        ne.ref_cnt = RefW'(1);
                        ne.dirty   = 1'b0;
                        ne.stamp   = stamp1;
                        n_stampc   = stamp1;
                    end
                end else if (r_mode == rtba_pkg::MODE_CLEAR) begin
                    gid = '0; n_ftop = '0; n_stop = '0; n_next = '0;
                    n_floc = '0; n_used = '0; n_stampc = '0;
                    n_mv_slow = '0; n_mv_fast = '0;
                end else if ({1'b0, r_id} >= r_next) begin
                    st = rtba_pkg::ST_BAD_ID;
                end else begin
                    show = 1'b1;
                    case (r_mode)
                        rtba_pkg::MODE_RELEASE: begin
                            if (e.ref_cnt == '0) begin
                                st = rtba_pkg::ST_FREE;
                            end else begin
                                ent_we = 1'b1;
                                ne.ref_cnt = e.ref_cnt - 1'b1;
                                if (ne.ref_cnt == '0) begin
                                    ne.dirty = 1'b0;
                                    n_used   = r_used - 1'b1;
                                    if (!e.tier) begin
                                        if (r_ftop < MaxCnt) begin
                                            fs_we   = 1'b1;
                                            fs_addr = IdW'(r_ftop);
                                            n_ftop  = r_ftop + 1'b1;
                                        end
                                    end else if (r_stop < MaxCnt) begin
                                        ss_we   = 1'b1;
                                        ss_addr = IdW'(r_stop);
                                        n_stop  = r_stop + 1'b1;
                                    end
                                end
                            end
                        end
                        rtba_pkg::MODE_ADDREF: begin
                            ent_we = 1'b1;
                            if (e.ref_cnt == '0) begin
                                n_used = r_used + 1'b1;
                            end
                            if (e.ref_cnt != '1) begin
                                ne.ref_cnt = e.ref_cnt + 1'b1;
                            end
                            ne.stamp = stamp1;
                            n_stampc = stamp1;
                        end
                        rtba_pkg::MODE_TOUCH: begin
                            ent_we   = 1'b1;
                            ne.stamp = stamp1;
                            n_stampc = stamp1;
                        end
                        rtba_pkg::MODE_TOSLOW: begin
                            if (e.tier) begin
                                st = rtba_pkg::ST_WRONG;
                            end else begin
                                ent_we = 1'b1; ne.tier = 1'b1;
                                n_floc = r_floc - 1'b1;
                                n_mv_slow = r_mv_slow + 32'd1;
                            end
                        end
                        rtba_pkg::MODE_TOFAST: begin
                            if (!e.tier) begin
                                st = rtba_pkg::ST_WRONG;
                            end else begin
                                ent_we = 1'b1; ne.tier = 1'b0;
                                n_floc = r_floc + 1'b1;
                                n_mv_fast = r_mv_fast + 32'd1;
                            end
                        end
                        default: begin
                            ent_we = 1'b1; ne.dirty = 1'b1;
                        end
                    endcase
                end
            end
            rtba_pkg::S_POP: begin
                // grant a block taken from a free stack; its tier is kept
                n_state    = rtba_pkg::S_IDLE;
                gid        = r_pid;
                ent_addr   = r_pid;
                ent_we     = 1'b1;
                show       = 1'b1;
                if (e.ref_cnt == '0) begin
                    n_used = r_used + 1'b1;
                end
                ne.ref_cnt = RefW'(1);
                ne.dirty   = 1'b0;
                ne.stamp   = stamp1;
                n_stampc   = stamp1;
            end
            default: n_state = rtba_pkg::S_IDLE;
        endcase
        ent_wdata = ne;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rtba_pkg::S_IDLE;
            r_ftop    <= '0;
            r_stop    <= '0;
            r_next    <= '0;
            r_floc    <= '0;
            r_used    <= '0;
            r_stampc  <= '0;
            r_mv_slow <= '0;
            r_mv_fast <= '0;
            o_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ftop    <= n_ftop;
            r_stop    <= n_stop;
            r_next    <= n_next;
            r_floc    <= n_floc;
            r_used    <= n_used;
            r_stampc  <= n_stampc;
            r_mv_slow <= n_mv_slow;
            r_mv_fast <= n_mv_fast;
            o_valid   <= done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_mode <= i_mode;
            r_id   <= i_block_id;
        end
        if (r_state == rtba_pkg::S_EXEC) begin
            r_pid <= gid;
        end
        if (done) begin
            o_status          <= st;
            o_granted_id      <= gid;
            o_ref_now         <= show ? ne.ref_cnt : '0;
            o_tier_now        <= show ? ne.tier : 1'b0;
            o_dirty_now       <= show ? ne.dirty : 1'b0;
            o_stamp_now       <= show ? ne.stamp : '0;
            o_created_count   <= n_next;
            o_fast_free_count <= n_ftop;
            o_slow_free_count <= n_stop;
            o_in_use_count    <= n_used;
            o_to_slow_moves   <= n_mv_slow;
            o_to_fast_moves   <= n_mv_fast;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rtba_pkg::S_EXEC |=> r_state != rtba_pkg::S_EXEC)
        else $error("exec phase lasted more than one cycle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) take |=> o_valid == 1'b0)
        else $error("result strobe too early");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> ##2 (o_valid || r_state == rtba_pkg::S_POP))
        else $error("missing result strobe");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rtba_pkg::S_POP |=> o_valid)
        else $error("missing result strobe after pop");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_ftop <= MaxCnt && r_stop <= MaxCnt)
        else $error("free stack top out of range");

endmodule

// File: rtl/rtba_ram.sv
// Generic single-port synchronous RAM with registered read.
module rtba_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule
